@@ hw/rtl/bfp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared constants, types and helpers for the bit field packer and unpacker.
// ----------------------------------------------------------------------------
package bfp_pkg;

    localparam int STORE_BYTES    = 1024;
    localparam int MAX_FIELD_BITS = 32;
    localparam int WORD_BITS      = 32;
    localparam int BYTE_BITS      = 8;
    localparam int WORD_BYTES     = WORD_BITS / BYTE_BITS;
    localparam int STORE_WORDS    = STORE_BYTES / WORD_BYTES;
    localparam int ADDR_W         = $clog2(STORE_WORDS);
    localparam int OFS_W          = $clog2(WORD_BITS);
    localparam int BYTE_OFS_W     = $clog2(BYTE_BITS);
    localparam int CAP_BITS       = STORE_BYTES * BYTE_BITS;
    localparam int PTR_W          = $clog2(CAP_BITS + 1);

    localparam int MODE_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int OUT_PTR_W = 14;

    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALIGN_W = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ALIGN_R = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PAST_END = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MERGE,
        ST_HIGH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [OFS_W-1:0]   offset;
        logic [COUNT_W-1:0] count;
    } field_ctl_t;

    function automatic logic [WORD_BITS-1:0] field_mask(input logic [COUNT_W-1:0] count);
        logic [WORD_BITS:0] t;
        t = ({{WORD_BITS{1'b0}}, 1'b1} << count) - {{WORD_BITS{1'b0}}, 1'b1};
        return t[WORD_BITS-1:0];
    endfunction

endpackage

@@ hw/rtl/bfp_ram.sv @@
// ----------------------------------------------------------------------------
// bfp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bfp_field.sv @@
// ----------------------------------------------------------------------------
// bfp_field
// Field shifter: merges a pushed field into store words, extracts a popped one.
// ----------------------------------------------------------------------------
module bfp_field (
    input  bfp_pkg::field_ctl_t                ctl,
    input  logic [bfp_pkg::VALUE_W-1:0]        value,
    input  logic [bfp_pkg::WORD_BITS-1:0]      lo_word,
    input  logic [bfp_pkg::WORD_BITS-1:0]      hi_word,
    output logic [bfp_pkg::WORD_BITS-1:0]      wr_lo,
    output logic [bfp_pkg::WORD_BITS-1:0]      wr_hi,
    output logic [bfp_pkg::VALUE_W-1:0]        pop_value
);

    logic [bfp_pkg::WORD_BITS-1:0]   mask;
    logic [bfp_pkg::WORD_BITS-1:0]   keep;
    logic [2*bfp_pkg::WORD_BITS-1:0] placed;
    logic [2*bfp_pkg::WORD_BITS-1:0] pulled;

    always_comb begin
        mask   = bfp_pkg::field_mask(ctl.count);
        // bits below the offset hold earlier fields, bits above are free
        keep   = bfp_pkg::field_mask(bfp_pkg::COUNT_W'(ctl.offset));
        placed = {{bfp_pkg::WORD_BITS{1'b0}}, value & mask} << ctl.offset;
        pulled = {hi_word, lo_word} >> ctl.offset;
        wr_lo     = (lo_word & keep) | placed[bfp_pkg::WORD_BITS-1:0];
        wr_hi     = placed[2*bfp_pkg::WORD_BITS-1:bfp_pkg::WORD_BITS];
        pop_value = pulled[bfp_pkg::VALUE_W-1:0] & mask;
    end

endmodule

@@ hw/rtl/bit_field_packer_unpacker.sv @@
// ----------------------------------------------------------------------------
// bit_field_packer_unpacker
// LSB-first bit stream packer over a 32-bit word store, one beat at a time.
// ----------------------------------------------------------------------------
// A beat is accepted in an idle cycle and passes through the FETCH and MERGE
// states, then a HIGH state when a push straddles two store words, and its
// result lands in the output register as it leaves the RESULT state. The
// word store, with one read and one write port, is read at the field's word
// and the next one, then written back at most twice. No new beat is taken
// until the current one has left the RESULT state. A new beat is accepted
// while the previous result waits to be taken, and then holds in the last
// stage until that result goes. The store is not cleared after reset; only
// bits below the write pointer are ever used, so no clearing pass is needed.
module bit_field_packer_unpacker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bfp_pkg::MODE_W-1:0]       s_mode,
    input  logic [bfp_pkg::VALUE_W-1:0]      s_field_value,
    input  logic [bfp_pkg::COUNT_W-1:0]      s_bit_count,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bfp_pkg::VALUE_W-1:0]      m_read_value,
    output logic [bfp_pkg::STATUS_W-1:0]     m_status,
    output logic [bfp_pkg::OUT_PTR_W-1:0]    m_bits_written,
    output logic [bfp_pkg::OUT_PTR_W-1:0]    m_bits_read
);

    localparam int PW = bfp_pkg::PTR_W;

    bfp_pkg::state_t state_reg, state_next;

    logic [PW-1:0]                    wp_reg, rp_reg;
    logic [bfp_pkg::ADDR_W-1:0]       addr_reg;
    bfp_pkg::field_ctl_t              ctl_reg;
    logic [bfp_pkg::VALUE_W-1:0]      value_reg;
    logic                             do_wr0_reg, do_wr1_reg, do_pop_reg;
    logic [bfp_pkg::STATUS_W-1:0]     status_reg;
    logic [bfp_pkg::WORD_BITS-1:0]    d0_reg;
    logic [bfp_pkg::VALUE_W-1:0]      val_reg;

    logic                             m_valid_reg;
    logic [bfp_pkg::VALUE_W-1:0]      m_value_reg;
    logic [bfp_pkg::STATUS_W-1:0]     m_status_reg;
    logic [bfp_pkg::OUT_PTR_W-1:0]    m_wp_reg, m_rp_reg;

    logic                             accept, load;
    logic [bfp_pkg::COUNT_W-1:0]      n_sat;
    logic [PW:0]                      wp_sum, rp_sum, wp_rnd_sum, rp_rnd_sum;
    logic [PW:0]                      wp_round, rp_round;
    logic [bfp_pkg::OFS_W+1:0]        span;
    logic                             use_wp;
    logic                             dec_wr0, dec_wr1, dec_pop;
    logic [bfp_pkg::STATUS_W-1:0]     dec_status;
    logic [PW-1:0]                    wp_new, rp_new;
    logic [bfp_pkg::COUNT_W-1:0]      dec_count;
    logic [bfp_pkg::OFS_W-1:0]        dec_offset;
    logic [bfp_pkg::ADDR_W-1:0]       dec_addr;

    logic                             ram_we;
    logic [bfp_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [bfp_pkg::WORD_BITS-1:0]    ram_wdata, ram_rdata;
    logic [bfp_pkg::WORD_BITS-1:0]    wr_lo, wr_hi;
    logic [bfp_pkg::VALUE_W-1:0]      pop_value;

    assign s_ready = (state_reg == bfp_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign load    = (state_reg == bfp_pkg::ST_RESULT) && (!m_valid_reg || m_ready);

    // beat decode against the current pointers
    always_comb begin
        n_sat = (s_bit_count > bfp_pkg::COUNT_W'(bfp_pkg::MAX_FIELD_BITS))
              ? bfp_pkg::COUNT_W'(bfp_pkg::MAX_FIELD_BITS) : s_bit_count;
        wp_sum     = {1'b0, wp_reg} + (PW+1)'(n_sat);
        rp_sum     = {1'b0, rp_reg} + (PW+1)'(n_sat);
        wp_rnd_sum = {1'b0, wp_reg} + (PW+1)'(bfp_pkg::BYTE_BITS - 1);
        rp_rnd_sum = {1'b0, rp_reg} + (PW+1)'(bfp_pkg::BYTE_BITS - 1);
        wp_round   = {wp_rnd_sum[PW:bfp_pkg::BYTE_OFS_W], {bfp_pkg::BYTE_OFS_W{1'b0}}};
        rp_round   = {rp_rnd_sum[PW:bfp_pkg::BYTE_OFS_W], {bfp_pkg::BYTE_OFS_W{1'b0}}};

        dec_wr0    = 1'b0;
        dec_wr1    = 1'b0;
        dec_pop    = 1'b0;
        dec_status = bfp_pkg::STATUS_OK;
        dec_count  = n_sat;
        wp_new     = wp_reg;
        rp_new     = rp_reg;
        use_wp     = 1'b1;

        case (s_mode)
            bfp_pkg::MODE_PUSH: begin
                if (n_sat != '0) begin
                    if (wp_sum > (PW+1)'(bfp_pkg::CAP_BITS)) begin
                        dec_status = bfp_pkg::STATUS_OVERFLOW;
                    end else begin
                        dec_wr0 = 1'b1;
                        dec_wr1 = (span > (bfp_pkg::OFS_W+2)'(bfp_pkg::WORD_BITS));
                        wp_new  = wp_sum[PW-1:0];
                    end
                end
            end
            bfp_pkg::MODE_POP: begin
                use_wp = 1'b0;
                if (n_sat != '0) begin
                    if (rp_sum > {1'b0, wp_reg}) begin
                        dec_status = bfp_pkg::STATUS_PAST_END;
                    end else begin
                        dec_pop = 1'b1;
                        rp_new  = rp_sum[PW-1:0];
                    end
                end
            end
            bfp_pkg::MODE_ALIGN_W: begin
                // pad bits up to the byte boundary become zero
                dec_count = '0;
                dec_wr0   = (wp_reg[bfp_pkg::BYTE_OFS_W-1:0] != '0);
                wp_new    = wp_round[PW-1:0];
            end
            bfp_pkg::MODE_ALIGN_R: begin
                if (rp_round > {1'b0, wp_reg}) begin
                    dec_status = bfp_pkg::STATUS_PAST_END;
                end else begin
                    rp_new = rp_round[PW-1:0];
                end
            end
            bfp_pkg::MODE_CLEAR: begin
                wp_new = '0;
                rp_new = '0;
            end
            default: begin
            end
        endcase
    end

    assign dec_offset = use_wp ? wp_reg[bfp_pkg::OFS_W-1:0] : rp_reg[bfp_pkg::OFS_W-1:0];
    assign dec_addr   = use_wp ? wp_reg[bfp_pkg::OFS_W +: bfp_pkg::ADDR_W]
                               : rp_reg[bfp_pkg::OFS_W +: bfp_pkg::ADDR_W];
    assign span = (bfp_pkg::OFS_W+2)'(wp_reg[bfp_pkg::OFS_W-1:0])
                + (bfp_pkg::OFS_W+2)'(n_sat);

    // store access
    always_comb begin
        ram_raddr = (state_reg == bfp_pkg::ST_IDLE) ? dec_addr : addr_reg + 1'b1;
        ram_we    = ((state_reg == bfp_pkg::ST_MERGE) && do_wr0_reg)
                 || ((state_reg == bfp_pkg::ST_HIGH) && do_wr1_reg);
        ram_waddr = (state_reg == bfp_pkg::ST_HIGH) ? addr_reg + 1'b1 : addr_reg;
        ram_wdata = (state_reg == bfp_pkg::ST_HIGH) ? wr_hi : wr_lo;
    end

    bfp_ram #(
        .WIDTH (bfp_pkg::WORD_BITS),
        .DEPTH (bfp_pkg::STORE_WORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfp_field u_field (
        .ctl       (ctl_reg),
        .value     (value_reg),
        .lo_word   (d0_reg),
        .hi_word   (ram_rdata),
        .wr_lo     (wr_lo),
        .wr_hi     (wr_hi),
        .pop_value (pop_value)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bfp_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = bfp_pkg::ST_FETCH;
                end
            end
            bfp_pkg::ST_FETCH: begin
                state_next = bfp_pkg::ST_MERGE;
            end
            bfp_pkg::ST_MERGE: begin
                state_next = do_wr1_reg ? bfp_pkg::ST_HIGH : bfp_pkg::ST_RESULT;
            end
            bfp_pkg::ST_HIGH: begin
                state_next = bfp_pkg::ST_RESULT;
            end
            bfp_pkg::ST_RESULT: begin
                if (load) begin
                    state_next = bfp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bfp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfp_pkg::ST_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            m_valid_reg <= 1'b0;
            do_wr0_reg  <= 1'b0;
            do_wr1_reg  <= 1'b0;
            do_pop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                wp_reg     <= wp_new;
                rp_reg     <= rp_new;
                do_wr0_reg <= dec_wr0;
                do_wr1_reg <= dec_wr1;
                do_pop_reg <= dec_pop;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg       <= dec_addr;
            ctl_reg.offset <= dec_offset;
            ctl_reg.count  <= dec_count;
            value_reg      <= s_field_value;
            status_reg     <= dec_status;
        end
        if (state_reg == bfp_pkg::ST_FETCH) begin
            d0_reg <= ram_rdata;
        end
        if (state_reg == bfp_pkg::ST_MERGE) begin
            val_reg <= do_pop_reg ? pop_value : '0;
        end
        if (load) begin
            m_value_reg  <= val_reg;
            m_status_reg <= status_reg;
            m_wp_reg     <= bfp_pkg::OUT_PTR_W'(wp_reg);
            m_rp_reg     <= bfp_pkg::OUT_PTR_W'(rp_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_value   = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_bits_written = m_wp_reg;
    assign m_bits_read    = m_rp_reg;

endmodule

@@ hw/rtl/bfp_checker.sv @@
// ----------------------------------------------------------------------------
// bfp_checker
// Port-level checks for the bit field packer and unpacker.
// ----------------------------------------------------------------------------
module bfp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [bfp_pkg::MODE_W-1:0]       s_mode,
    input logic [bfp_pkg::VALUE_W-1:0]      s_field_value,
    input logic [bfp_pkg::COUNT_W-1:0]      s_bit_count,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [bfp_pkg::VALUE_W-1:0]      m_read_value,
    input logic [bfp_pkg::STATUS_W-1:0]     m_status,
    input logic [bfp_pkg::OUT_PTR_W-1:0]    m_bits_written,
    input logic [bfp_pkg::OUT_PTR_W-1:0]    m_bits_read
);

    // the read pointer never passes the write pointer
    a_read_behind_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bits_read <= m_bits_written))
        else $error("read pointer ahead of write pointer");

    // a failed beat returns no data
    a_error_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != bfp_pkg::STATUS_OK)) |-> (m_read_value == '0))
        else $error("data returned with error status");

    // no unknown status codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == bfp_pkg::STATUS_OK)
                  || (m_status == bfp_pkg::STATUS_OVERFLOW)
                  || (m_status == bfp_pkg::STATUS_PAST_END)))
        else $error("unknown status code");

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_value)
                                  && $stable(m_status) && $stable(m_bits_written)
                                  && $stable(m_bits_read)))
        else $error("result beat changed while stalled");

endmodule

bind bit_field_packer_unpacker bfp_checker u_bfp_checker (.*);
